### sv/ptmb_pkg.sv
// shared types and constants for the page table map builder
`default_nettype none
package ptmb_pkg;

  localparam int IDX_W       = 9;
  localparam int ENTRIES     = 512;
  localparam int FRAME_W     = 40;
  localparam int FLAGS_W     = 12;
  localparam int ENTRY_W     = FRAME_W + FLAGS_W;
  localparam int VPN_W       = 36;
  localparam int ADDED_W     = 2;
  localparam int IN_USE_W    = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int LEVEL_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROOT_FRAME  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_FLAGS = 1'b1;

  localparam logic [FRAME_W-1:0] ROOT_FRAME_RST  = 40'd512;
  localparam logic [FLAGS_W-1:0] ENTRY_FLAGS_RST = 12'd3;

  localparam logic [LEVEL_W-1:0] LEVEL_ROOT = 2'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_DIR  = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_LEAF,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic chk;
    logic leaf;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic present;
    logic pool_full;
    logic last_level;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### sv/ptmb_ctrl.sv
// walk sequencer for the page table map builder
`default_nettype none
module ptmb_ctrl
  import ptmb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_CHECK;
      ST_CHECK: begin
        priority if (!sts.present && sts.pool_full) state_nxt = ST_FINISH;
        else if (sts.last_level) state_nxt = ST_LEAF;
        else state_nxt = ST_READ;
      end
      ST_LEAF: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_READ:   cmd.rd   = 1'b1;
      ST_CHECK:  cmd.chk  = 1'b1;
      ST_LEAF:   cmd.leaf = 1'b1;
      ST_FINISH: cmd.fin  = sts.out_free;
      default:   cmd      = '0;
    endcase
  end

endmodule
`default_nettype wire

### sv/ptmb_datapath.sv
// table store, allocator, walk registers and result register
`default_nettype none
module ptmb_datapath
  import ptmb_pkg::*;
#(
  parameter int MAX_TABLES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic [VPN_W-1:0]     in_virt_page,
  input  wire logic [FRAME_W-1:0]   in_phys_page,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FRAME_W-1:0]   cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_status,
  output logic [ADDED_W-1:0]        out_tables_added,
  output logic [IN_USE_W-1:0]       out_tables_in_use,
  output logic [ENTRY_W-1:0]        out_leaf_value
);

  localparam int TW    = $clog2(MAX_TABLES);
  localparam int NW    = $clog2(MAX_TABLES + 1);
  localparam int AW    = TW + IDX_W;
  localparam int DEPTH = MAX_TABLES * ENTRIES;

  logic [ENTRY_W-1:0] mem [DEPTH];

  logic [FRAME_W-1:0] root_frame_r;
  logic [FLAGS_W-1:0] entry_flags_r;
  logic [VPN_W-1:0]   vp_r;
  logic [FRAME_W-1:0] pp_r;
  logic [TW-1:0]      table_r;
  logic [LEVEL_W-1:0] level_r;
  logic [NW-1:0]      next_free_r;
  logic [ADDED_W-1:0] added_r;
  logic               fail_r;
  logic [AW-1:0]      clr_addr_r;
  logic [ENTRY_W-1:0] rd_data_r;

  logic [IDX_W-1:0]   idx;
  logic [AW-1:0]      mem_addr;
  logic [FRAME_W-1:0] diff;
  logic [NW-1:0]      child;
  logic               alloc;
  logic               we;
  logic [ENTRY_W-1:0] wdata;

  // index field of the current level
  always_comb begin
    unique case (level_r)
      2'd3:    idx = vp_r[35:27];
      2'd2:    idx = vp_r[26:18];
      2'd1:    idx = vp_r[17:9];
      default: idx = vp_r[8:0];
    endcase
  end

  // child decode: frame field relative to the root frame
  assign diff  = rd_data_r[ENTRY_W-1:FLAGS_W] - root_frame_r;
  assign child = diff[NW-1:0];

  assign sts.present    = (rd_data_r != '0) && (diff[FRAME_W-1:NW] == '0)
                          && (child != '0) && (child < next_free_r);
  assign sts.pool_full  = next_free_r >= NW'(MAX_TABLES);
  assign sts.last_level = level_r == LEVEL_DIR;
  assign sts.clear_last = clr_addr_r == AW'(DEPTH - 1);
  assign sts.out_free   = !out_valid || !out_stall;

  assign alloc    = cmd.chk && !sts.present && !sts.pool_full;
  assign mem_addr = cmd.clr ? clr_addr_r : {table_r, idx};
  assign we       = cmd.clr || cmd.leaf || alloc;

  always_comb begin
    priority if (cmd.clr) wdata = '0;
    else if (cmd.leaf) wdata = {pp_r, entry_flags_r};
    else wdata = {root_frame_r + FRAME_W'(next_free_r), entry_flags_r};
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[mem_addr] <= wdata;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_frame_r  <= ROOT_FRAME_RST;
      entry_flags_r <= ENTRY_FLAGS_RST;
      next_free_r   <= NW'(1);
      clr_addr_r    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ROOT_FRAME:  root_frame_r  <= cfg_data;
          REG_ENTRY_FLAGS: entry_flags_r <= cfg_data[FLAGS_W-1:0];
          default:         root_frame_r  <= root_frame_r;
        endcase
      end
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (alloc) begin
        next_free_r <= next_free_r + NW'(1);
      end
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vp_r    <= in_virt_page;
      pp_r    <= in_phys_page;
      table_r <= '0;
      level_r <= LEVEL_ROOT;
      added_r <= '0;
      fail_r  <= 1'b0;
    end else if (cmd.chk) begin
      if (sts.present) begin
        table_r <= child[TW-1:0];
        level_r <= level_r - LEVEL_W'(1);
      end else if (sts.pool_full) begin
        fail_r <= 1'b1;
      end else begin
        table_r <= next_free_r[TW-1:0];
        level_r <= level_r - LEVEL_W'(1);
        added_r <= added_r + ADDED_W'(1);
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_status        <= fail_r;
      out_tables_added  <= added_r;
      out_tables_in_use <= IN_USE_W'(next_free_r);
      out_leaf_value    <= fail_r ? '0 : {pp_r, entry_flags_r};
    end
  end

endmodule
`default_nettype wire

### sv/page_table_map_builder.sv
// top level of the four-level page table map builder
// an input beat runs to a result beat with all levels walked, or stops early
// when the pool runs out; one item at a time, so a new item waits for the last;
// the walk is three read-then-check steps and the leaf write on one table memory port
// reset: the table store is swept to zero, one entry a cycle, all MAX_TABLES * 512
// entries (524288 by default), before the first input beat; config writes meanwhile
`default_nettype none
module page_table_map_builder
  import ptmb_pkg::*;
#(
  parameter int MAX_TABLES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [VPN_W-1:0]     in_virt_page,
  input  wire logic [FRAME_W-1:0]   in_phys_page,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_status,
  output logic [ADDED_W-1:0]        out_tables_added,
  output logic [IN_USE_W-1:0]       out_tables_in_use,
  output logic [ENTRY_W-1:0]        out_leaf_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FRAME_W-1:0]   cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ptmb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptmb_datapath #(
    .MAX_TABLES (MAX_TABLES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_virt_page      (in_virt_page),
    .in_phys_page      (in_phys_page),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_tables_added  (out_tables_added),
    .out_tables_in_use (out_tables_in_use),
    .out_leaf_value    (out_leaf_value)
  );

endmodule
`default_nettype wire

### tb/page_table_map_builder_tb.sv
// self-checking testbench for the page table map builder against a walk model
module page_table_map_builder_tb;
  import ptmb_pkg::*;

  localparam int MAX_TABLES   = 1024;
  localparam int WATCHDOG_MAX = 1_600_000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [VPN_W-1:0]   vp;
    logic [FRAME_W-1:0] pp;
  } page_req_t;

  typedef struct packed {
    logic                status;
    logic [ADDED_W-1:0]  added;
    logic [IN_USE_W-1:0] in_use;
    logic [ENTRY_W-1:0]  leaf;
  } map_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [VPN_W-1:0]     in_virt_page = '0;
  logic [FRAME_W-1:0]   in_phys_page = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_status;
  logic [ADDED_W-1:0]   out_tables_added;
  logic [IN_USE_W-1:0]  out_tables_in_use;
  logic [ENTRY_W-1:0]   out_leaf_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROOT_FRAME;
  logic [FRAME_W-1:0]   cfg_data = '0;

  logic [ENTRY_W-1:0] walk_store [int unsigned];
  int unsigned        tables_next = 1;
  logic [FRAME_W-1:0] cur_root = ROOT_FRAME_RST;
  logic [FLAGS_W-1:0] cur_flags = ENTRY_FLAGS_RST;

  page_req_t        pending_pages[$];
  map_result_t      expected_maps[$];
  logic [VPN_W-1:0] mapped_vps[$];
  logic [IDX_W-1:0] root_pick[2];
  logic [IDX_W-1:0] ptr_pick[3];
  logic [IDX_W-1:0] dir_pick[4];

  bit idle_on = 1'b1;
  bit in_busy = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;

  page_table_map_builder #(.MAX_TABLES(MAX_TABLES)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_virt_page      (in_virt_page),
    .in_phys_page      (in_phys_page),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_tables_added  (out_tables_added),
    .out_tables_in_use (out_tables_in_use),
    .out_leaf_value    (out_leaf_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic map_result_t map_page(input logic [VPN_W-1:0] vp,
                                           input logic [FRAME_W-1:0] pp);
    map_result_t        r;
    int unsigned        tbl;
    int unsigned        pos;
    int unsigned        child;
    int                 lvl;
    logic [ENTRY_W-1:0] ent;
    logic [FRAME_W-1:0] delta;
    r = '0;
    tbl = 0;
    lvl = 3;
    while (lvl >= 1 && !r.status) begin
      pos = tbl * ENTRIES + vp[lvl*IDX_W +: IDX_W];
      ent = walk_store.exists(pos) ? walk_store[pos] : '0;
      delta = ent[ENTRY_W-1:FLAGS_W] - cur_root;
      child = (ent != '0 && delta >= 1 && delta < tables_next) ? 32'(delta) : 0;
      if (child == 0) begin
        if (tables_next >= MAX_TABLES) begin
          r.status = 1'b1;
        end else begin
          child = tables_next;
          tables_next++;
          r.added = r.added + 1'b1;
          walk_store[pos] = {cur_root + FRAME_W'(child), cur_flags};
        end
      end
      tbl = child;
      lvl--;
    end
    if (!r.status) begin
      r.leaf = {pp, cur_flags};
      walk_store[tbl * ENTRIES + vp[IDX_W-1:0]] = r.leaf;
    end
    r.in_use = IN_USE_W'(tables_next);
    return r;
  endfunction

  function automatic logic [VPN_W-1:0] any_vp();
    return VPN_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [FRAME_W-1:0] any_frame();
    return FRAME_W'({$urandom(), $urandom()});
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ROOT_FRAME) cur_root = data;
    else cur_flags = data[FLAGS_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_pages.size() != 0 || in_busy || expected_maps.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pick_paths();
    foreach (root_pick[i]) root_pick[i] = IDX_W'($urandom);
    foreach (ptr_pick[i]) ptr_pick[i] = IDX_W'($urandom);
    foreach (dir_pick[i]) dir_pick[i] = IDX_W'($urandom);
  endtask

  // pages inside a few shared subtrees, wild_pct percent of them anywhere
  task automatic add_pages(input int count, input int wild_pct);
    logic [VPN_W-1:0] vp;
    repeat (count) begin
      if ($urandom_range(0, 99) < wild_pct) vp = any_vp();
      else vp = {root_pick[$urandom_range(0, 1)], ptr_pick[$urandom_range(0, 2)],
                 dir_pick[$urandom_range(0, 3)], IDX_W'($urandom)};
      mapped_vps.push_back(vp);
      pending_pages.push_back('{vp, any_frame()});
    end
  endtask

  always @(negedge clk) begin
    page_req_t req;
    if (rst_n && !in_busy) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_pages.size() != 0) begin
        if (idle_on && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 14) - 1;
          in_valid <= 1'b0;
        end else begin
          req = pending_pages.pop_front();
          in_virt_page <= req.vp;
          in_phys_page <= req.pp;
          in_valid <= 1'b1;
          in_busy = 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (idle_on && stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    map_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_maps.push_back(map_page(in_virt_page, in_phys_page));
        in_busy = 1'b0;
      end
      if (out_valid && !out_stall) begin
        if (expected_maps.size() == 0) begin
          $error("result beat with no mapping outstanding");
          fail_count++;
        end else begin
          want = expected_maps.pop_front();
          check_field("status", want.status, out_status);
          check_field("tables_added", want.added, out_tables_added);
          check_field("tables_in_use", want.in_use, out_tables_in_use);
          check_field("leaf_value", want.leaf, out_leaf_value);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("[page_table_map_builder] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // frame numbers wrap past the top of the address field here
    write_reg(REG_ROOT_FRAME, 40'hFF_FFFF_FFFE);
    write_reg(REG_ENTRY_FLAGS, 12'hFFF);
    pending_pages.push_back('{36'h0, 40'h0});
    pending_pages.push_back('{36'h0, 40'hFF_FFFF_FFFF});
    pending_pages.push_back('{36'h1, 40'h1});
    pending_pages.push_back('{36'hF_FFFF_FFFF, 40'hFF_FFFF_FFFF});
    pending_pages.push_back('{36'h0_0000_0200, 40'h55_5555_5555});
    pending_pages.push_back('{36'h0_0004_0000, 40'hAA_AAAA_AAAA});
    pending_pages.push_back('{36'h0_0800_0000, 40'h80_0000_0000});
    pending_pages.push_back('{36'hA_AAAA_AAAA, 40'hAA_AAAA_AAAA});
    pending_pages.push_back('{36'h5_5555_5555, 40'h55_5555_5555});
    pending_pages.push_back('{36'h8_0000_0000, 40'h00_0000_0001});
    pending_pages.push_back('{36'hF_F800_0000, 40'h12_3456_789A});
    pending_pages.push_back('{36'h0_07FC_0000, 40'h0F_0F0F_0F0F});
    pending_pages.push_back('{36'h0_0003_FE00, 40'hF0_F0F0_F0F0});
    pending_pages.push_back('{36'h0_0000_01FF, 40'hFF_FFFF_FFFE});
    pending_pages.push_back('{36'hF_FFFF_FFFF, 40'h0});
    drain_all();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_ROOT_FRAME, '0);
          write_reg(REG_ENTRY_FLAGS, '0);
        end
        1: begin
          write_reg(REG_ROOT_FRAME, 40'hFF_FFFF_FFFF);
          write_reg(REG_ENTRY_FLAGS, 12'hFFF);
          idle_on = 1'b0;
        end
        2: begin
          write_reg(REG_ROOT_FRAME, ROOT_FRAME_RST);
          write_reg(REG_ENTRY_FLAGS, ENTRY_FLAGS_RST);
          idle_on = 1'b1;
        end
        3: begin
          write_reg(REG_ROOT_FRAME, any_frame());
          write_reg(REG_ENTRY_FLAGS, FRAME_W'($urandom_range(0, 4095)));
        end
        4: begin
          write_reg(REG_ROOT_FRAME, cur_root + FRAME_W'($urandom_range(1, 3)));
          mapped_vps.delete();
        end
        default: write_reg(REG_ENTRY_FLAGS, FRAME_W'($urandom_range(0, 4095)));
      endcase
      pick_paths();
      if (phase == 5) begin
        // run the pool dry, then revisit known pages and add new ones with no idling
        add_pages(340, 100);
        drain_all();
        idle_on = 1'b0;
        repeat (30)
          pending_pages.push_back('{mapped_vps[$urandom_range(0, mapped_vps.size() - 1)],
                                    any_frame()});
        add_pages(30, 0);
      end else begin
        add_pages(145, 4);
        if (phase == 2) drain_all();
        add_pages(145, 4);
      end
      drain_all();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("[page_table_map_builder] OK");
    else $display("[page_table_map_builder] ERROR");
    $finish;
  end

endmodule

### filelist.f
sv/ptmb_pkg.sv
sv/ptmb_ctrl.sv
sv/ptmb_datapath.sv
sv/page_table_map_builder.sv
tb/page_table_map_builder_tb.sv
